[src/mi4_pkg.sv]
package mi4_pkg;

   typedef enum logic [3:0] {
      S_LOAD,
      S_CF_A,
      S_CF_B,
      S_MUL1,
      S_CF_C,
      S_MUL2,
      S_CF_ACC,
      S_DT_A,
      S_DMUL,
      S_DT_ACC,
      S_DV_INIT,
      S_DV_STEP,
      S_DV_END,
      S_SEND
   } state_type;

   localparam int NUM_PERMS = 6;
   localparam logic [3:0] LAST_INDEX = 4'd15;

   // column of the minor used by factor k of permutation p
   function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] k);
      logic [5:0] cols;
      unique case (p)
         3'd0:    cols = {2'd2, 2'd1, 2'd0};
         3'd1:    cols = {2'd1, 2'd2, 2'd0};
         3'd2:    cols = {2'd2, 2'd0, 2'd1};
         3'd3:    cols = {2'd0, 2'd2, 2'd1};
         3'd4:    cols = {2'd1, 2'd0, 2'd2};
         3'd5:    cols = {2'd0, 2'd1, 2'd2};
         default: cols = {2'd2, 2'd1, 2'd0};
      endcase
      unique case (k)
         2'd0:    perm_col = cols[1:0];
         2'd1:    perm_col = cols[3:2];
         default: perm_col = cols[5:4];
      endcase
   endfunction

   function automatic logic perm_odd(input logic [2:0] p);
      perm_odd = (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
   endfunction

   // index k of the minor mapped back past the skipped row or column
   function automatic logic [1:0] skip_idx(input logic [1:0] skip, input logic [1:0] k);
      skip_idx = (k < skip) ? k : k + 2'd1;
   endfunction

endpackage

[src/matrix_inverse_4x4.sv]
// channel | dir | beat                          | fields
// req_    | in  | one matrix element            | tdata: element
// rsp_    | out | one inverse element           | tdata: inverse_element, position;
//         |     |                               | tuser: singular, saturated; tlast: last
// sixteen beats load the matrix, one per cycle while loading
// then a bit-serial multiply-accumulate unit forms 16 cofactors (96 triple products)
// and the determinant
// a restoring divider then forms each inverse element before its beat
// req_tready is low from the sixteenth element until the last result beat is taken
// reset is synchronous and returns the load counter to zero
module matrix_inverse_4x4 #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]     req_tdata,  // element
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((DATA_WIDTH+4+7)/8)*8-1:0]   rsp_tdata,  // inverse_element, position
   output logic [1:0]                          rsp_tuser,  // singular, saturated
   output logic                                rsp_tlast
);
   import mi4_pkg::*;

   localparam int W    = DATA_WIDTH;
   localparam int CW   = 3 * W + 1;
   localparam int PW   = 4 * W + 3;
   localparam int NB   = 3 * W + 2 * FRAC_BITS;
   localparam int BCW  = $clog2(NB);
   localparam int OW   = ((DATA_WIDTH + 4 + 7) / 8) * 8;

   state_type state_ff, state_in;

   logic [3:0]     load_cnt_ff, load_cnt_in;
   logic [W-1:0]   store_ff [16];
   logic [CW-1:0]  cof_ff [16];
   logic [3:0]     cof_idx_ff, cof_idx_in;
   logic [2:0]     perm_ff, perm_in;
   logic [BCW-1:0] bit_cnt_ff, bit_cnt_in;
   logic [PW-1:0]  x_ff, x_in;
   logic [W-1:0]   y_ff, y_in;
   logic [PW-1:0]  p_ff, p_in;
   logic [CW-1:0]  acc_ff, acc_in;
   logic [PW-1:0]  det_ff, det_in;
   logic [3:0]     out_idx_ff, out_idx_in;
   logic [NB-1:0]  num_ff, num_in;
   logic [PW-1:0]  rem_ff, rem_in;
   logic [NB-1:0]  q_ff, q_in;
   logic           neg_ff, neg_in;
   logic [W-1:0]   data_ff, data_in;
   logic           sat_ff, sat_in;

   logic           req_fire, rsp_fire;
   logic [1:0]     factor;
   logic [3:0]     el_rd_idx;
   logic [W-1:0]   el_rd;
   logic [3:0]     cof_rd_idx;
   logic [CW-1:0]  cof_rd;
   logic [PW-1:0]  addend;
   logic [PW-1:0]  mul_next;
   logic           mul_done, div_done;
   logic           det_zero;
   logic [PW-1:0]  dmag;
   logic [CW-1:0]  cmag;
   logic [PW:0]    trial, trial_diff;
   logic [NB-1:0]  limit;
   logic [NB-1:0]  mag;
   logic           cof_store;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign mul_done = bit_cnt_ff == BCW'(W - 1);
   assign div_done = bit_cnt_ff == BCW'(NB - 1);
   assign det_zero = det_ff == '0;
   assign dmag     = det_ff[PW-1] ? -det_ff : det_ff;

   // element read port
   always_comb begin
      unique case (state_ff)
         S_CF_A:  factor = 2'd0;
         S_CF_B:  factor = 2'd1;
         default: factor = 2'd2;
      endcase
      if (state_ff == S_DT_A) begin
         el_rd_idx = {2'd0, cof_idx_ff[1:0]};
      end else begin
         el_rd_idx = {skip_idx(cof_idx_ff[3:2], factor),
                      skip_idx(cof_idx_ff[1:0], perm_col(perm_ff, factor))};
      end
      el_rd = store_ff[el_rd_idx];
   end

   // cofactor read port, transposed for the division phase
   always_comb begin
      if (state_ff == S_DT_A) begin
         cof_rd_idx = cof_idx_ff;
      end else begin
         cof_rd_idx = {out_idx_ff[1:0], out_idx_ff[3:2]};
      end
      cof_rd = cof_ff[cof_rd_idx];
      cmag   = cof_rd[CW-1] ? -cof_rd : cof_rd;
   end

   // shift-add multiply step, msb first, sign bit has negative weight
   always_comb begin
      if (y_ff[W-1]) begin
         addend = (bit_cnt_ff == '0) ? -x_ff : x_ff;
      end else begin
         addend = '0;
      end
      mul_next = {p_ff[PW-2:0], 1'b0} + addend;
   end

   always_comb begin
      trial      = {rem_ff, num_ff[NB-1]};
      trial_diff = trial - {1'b0, dmag};
      limit      = NB'(1) << (W - 1);
      if (!neg_ff) begin
         limit = limit - NB'(1);
      end
      mag = (q_ff > limit) ? limit : q_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_fire && load_cnt_ff == LAST_INDEX) state_in = S_CF_A;
         end
         S_CF_A:  state_in = S_CF_B;
         S_CF_B:  state_in = S_MUL1;
         S_MUL1: begin
            if (mul_done) state_in = S_CF_C;
         end
         S_CF_C:  state_in = S_MUL2;
         S_MUL2: begin
            if (mul_done) state_in = S_CF_ACC;
         end
         S_CF_ACC: begin
            if (perm_ff == 3'(NUM_PERMS - 1) && cof_idx_ff == LAST_INDEX) begin
               state_in = S_DT_A;
            end else begin
               state_in = S_CF_A;
            end
         end
         S_DT_A:  state_in = S_DMUL;
         S_DMUL: begin
            if (mul_done) state_in = S_DT_ACC;
         end
         S_DT_ACC: begin
            state_in = (cof_idx_ff[1:0] == 2'd3) ? S_DV_INIT : S_DT_A;
         end
         S_DV_INIT: begin
            state_in = det_zero ? S_SEND : S_DV_STEP;
         end
         S_DV_STEP: begin
            if (div_done) state_in = S_DV_END;
         end
         S_DV_END: state_in = S_SEND;
         S_SEND: begin
            if (rsp_fire) state_in = (out_idx_ff == LAST_INDEX) ? S_LOAD : S_DV_INIT;
         end
         default: state_in = S_LOAD;
      endcase
   end

   // datapath
   always_comb begin
      load_cnt_in = load_cnt_ff;
      cof_idx_in  = cof_idx_ff;
      perm_in     = perm_ff;
      bit_cnt_in  = bit_cnt_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      p_in        = p_ff;
      acc_in      = acc_ff;
      det_in      = det_ff;
      out_idx_in  = out_idx_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      q_in        = q_ff;
      neg_in      = neg_ff;
      data_in     = data_ff;
      sat_in      = sat_ff;
      cof_store   = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) load_cnt_in = load_cnt_ff + 4'd1;
            cof_idx_in = '0;
            perm_in    = '0;
            acc_in     = '0;
            det_in     = '0;
            out_idx_in = '0;
         end
         S_CF_A: begin
            x_in       = {{(PW-W){el_rd[W-1]}}, el_rd};
            bit_cnt_in = '0;
         end
         S_CF_B, S_CF_C: begin
            if (state_ff == S_CF_C) x_in = p_ff;
            y_in = el_rd;
            p_in = '0;
         end
         S_MUL1, S_MUL2, S_DMUL: begin
            p_in       = mul_next;
            y_in       = {y_ff[W-2:0], 1'b0};
            bit_cnt_in = mul_done ? '0 : bit_cnt_ff + BCW'(1);
         end
         S_CF_ACC: begin
            if (perm_odd(perm_ff) ^ (cof_idx_ff[2] ^ cof_idx_ff[0])) begin
               acc_in = acc_ff - p_ff[CW-1:0];
            end else begin
               acc_in = acc_ff + p_ff[CW-1:0];
            end
            if (perm_ff == 3'(NUM_PERMS - 1)) begin
               cof_store  = 1'b1;
               perm_in    = '0;
               cof_idx_in = cof_idx_ff + 4'd1;
            end else begin
               perm_in = perm_ff + 3'd1;
            end
         end
         S_DT_A: begin
            x_in       = {{(PW-CW){cof_rd[CW-1]}}, cof_rd};
            y_in       = el_rd;
            p_in       = '0;
            bit_cnt_in = '0;
         end
         S_DT_ACC: begin
            det_in     = det_ff + p_ff;
            cof_idx_in = {2'd0, cof_idx_ff[1:0] + 2'd1};
         end
         S_DV_INIT: begin
            num_in     = {cmag[CW-2:0], {(2*FRAC_BITS){1'b0}}};
            neg_in     = cof_rd[CW-1] ^ det_ff[PW-1];
            rem_in     = '0;
            q_in       = '0;
            bit_cnt_in = '0;
            data_in    = '0;
            sat_in     = 1'b0;
         end
         S_DV_STEP: begin
            num_in = {num_ff[NB-2:0], 1'b0};
            if (!trial_diff[PW]) begin
               rem_in = trial_diff[PW-1:0];
               q_in   = {q_ff[NB-2:0], 1'b1};
            end else begin
               rem_in = trial[PW-1:0];
               q_in   = {q_ff[NB-2:0], 1'b0};
            end
            bit_cnt_in = bit_cnt_ff + BCW'(1);
         end
         S_DV_END: begin
            sat_in  = q_ff > limit;
            data_in = neg_ff ? -mag[W-1:0] : mag[W-1:0];
         end
         S_SEND: begin
            if (rsp_fire) out_idx_in = out_idx_ff + 4'd1;
         end
         default: ;
      endcase
      if (cof_store) acc_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         load_cnt_ff <= '0;
         cof_idx_ff  <= '0;
         perm_ff     <= '0;
         bit_cnt_ff  <= '0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         cof_idx_ff  <= cof_idx_in;
         perm_ff     <= perm_in;
         bit_cnt_ff  <= bit_cnt_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      p_ff    <= p_in;
      acc_ff  <= acc_in;
      det_ff  <= det_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      data_ff <= data_in;
      sat_ff  <= sat_in;
      if (req_fire) store_ff[load_cnt_ff] <= req_tdata[W-1:0];
      if (cof_store) begin
         if (perm_odd(perm_ff) ^ (cof_idx_ff[2] ^ cof_idx_ff[0])) begin
            cof_ff[cof_idx_ff] <= acc_ff - p_ff[CW-1:0];
         end else begin
            cof_ff[cof_idx_ff] <= acc_ff + p_ff[CW-1:0];
         end
      end
   end

   assign req_tready = state_ff == S_LOAD;
   assign rsp_tvalid = state_ff == S_SEND;
   assign rsp_tdata  = OW'({out_idx_ff, data_ff});
   assign rsp_tuser  = {sat_ff, det_zero};
   assign rsp_tlast  = out_idx_ff == LAST_INDEX;

endmodule

[src/mi4_checker.sv]
module mi4_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((DATA_WIDTH+4+7)/8)*8-1:0] rsp_tdata,
   input logic [1:0]                        rsp_tuser,
   input logic                              rsp_tlast
);

   localparam int W = DATA_WIDTH;

   // busy while results are out
   a_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while results pending");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[W+3:W] == 4'd15)))
      else $error("last flag does not match position");

   a_singular: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[W-1:0] == '0 && !rsp_tuser[1]))
      else $error("singular beat carries data");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled beat changed");

endmodule

bind matrix_inverse_4x4 mi4_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mi4_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
